// ----- src/fla_pkg.sv -----
// Shared types and constants for the free list node allocator.
// No dependencies; every other file but fla_ram imports this package.
package fla_pkg;

   localparam int OFFSET_W   = 16;
   localparam int STATUS_W   = 3;
   localparam int RSP_IDX_W  = 6;

   localparam int POOL_NODES_DEF = 64;
   localparam int NODE_BYTES_DEF = 32;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_UNALIGNED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DOUBLE    = 3'd4;

   typedef struct packed {
      logic                kind;
      logic [OFFSET_W-1:0] free_offset;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [RSP_IDX_W-1:0] node_index;
   } rsp_type;

   typedef struct packed {
      logic lt;
      logic eq;
   } alu_flags_type;

endpackage

// ----- src/fla_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module fla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/fla_alu.sv -----
// Shared compare unit used for range check, alignment check and list walk.
// Depends on fla_pkg.
module fla_alu #(
   parameter int W = 16
) (
   input  logic [W-1:0]           a,
   input  logic [W-1:0]           b,
   output fla_pkg::alu_flags_type flags
);
   import fla_pkg::*;

   assign flags.lt = (a < b);
   assign flags.eq = (a == b);

endmodule

// ----- src/free_list_node_allocator.sv -----
// Free list node allocator: top level. Depends on fla_pkg, fla_ram and fla_alu.
// Node links live in one RAM; a sequencer drives one shared compare unit.
// After reset a fill pass writes the initial chain, with req_ready low. An
// allocate passes through S_ALLOC and then S_RESP (only S_RESP when the pool
// is empty). A free passes a range check in S_RANGE (then S_RESP when out of
// range), an alignment check in S_ALIGN on a reciprocal multiply by NODE_BYTES
// (then S_RESP when unaligned), then S_WALK, with S_WAIT and S_WALK again for
// each list link passed, up to POOL_NODES, then S_RESP, plus any rsp_ready wait.
// req_ready returns in the same cycle as the result is posted. One request is in
// flight at a time; a new one is taken while the previous result still waits on
// rsp_ready, and its own result is held back until that one is taken.
module free_list_node_allocator #(
   parameter int POOL_NODES = fla_pkg::POOL_NODES_DEF,
   parameter int NODE_BYTES = fla_pkg::NODE_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fla_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fla_pkg::rsp_type rsp_data
);
   import fla_pkg::*;

   localparam int IDX_W      = $clog2(POOL_NODES);
   localparam int LINK_W     = $clog2(POOL_NODES + 1);
   localparam int STEP_W     = $clog2(POOL_NODES + 1);
   localparam int POOL_BYTES = POOL_NODES * NODE_BYTES;
   localparam int PB_W       = $clog2(POOL_BYTES + 1);
   localparam int ALU_W      = (PB_W > OFFSET_W) ? PB_W : OFFSET_W;
   localparam int WIDE_W     = IDX_W + RSP_IDX_W;
   localparam int NB_LOG     = $clog2(NODE_BYTES);
   localparam int DIV_SH     = OFFSET_W + NB_LOG;
   localparam int MUL_W      = OFFSET_W + 1;
   localparam int PROD_W     = OFFSET_W + MUL_W;
   localparam int DIV_MUL    = ((1 << DIV_SH) + NODE_BYTES - 1) / NODE_BYTES;
   localparam logic [MUL_W-1:0]  DIV_MUL_C = MUL_W'(DIV_MUL);
   localparam logic [LINK_W-1:0] LINK_END  = LINK_W'(POOL_NODES);

   typedef enum logic [7:0] {
      S_INIT  = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_RANGE = 8'b0000_0100,
      S_ALIGN = 8'b0000_1000,
      S_WALK  = 8'b0001_0000,
      S_WAIT  = 8'b0010_0000,
      S_ALLOC = 8'b0100_0000,
      S_RESP  = 8'b1000_0000
   } state_type;

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       init_cnt_ff, init_cnt_in;
   logic [LINK_W-1:0]      head_ff, head_in;
   logic [LINK_W-1:0]      cur_ff, cur_in;
   logic [IDX_W-1:0]       node_ff, node_in;
   logic [STEP_W-1:0]      steps_ff, steps_in;
   logic [OFFSET_W-1:0]    offset_ff, offset_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   ram_we;
   logic [IDX_W-1:0]       ram_wr_addr;
   logic [LINK_W-1:0]      ram_wr_data;
   logic [IDX_W-1:0]       ram_rd_addr;
   logic [LINK_W-1:0]      ram_rd_data;

   logic [ALU_W-1:0]       alu_a, alu_b;
   alu_flags_type          alu_flags;

   logic [PROD_W-1:0]      div_prod;
   logic [IDX_W-1:0]       div_quo;
   logic [ALU_W-1:0]       node_base;
   logic                   walk_done;
   logic [WIDE_W-1:0]      idx_wide;

   fla_ram #(
      .WIDTH (LINK_W),
      .DEPTH (POOL_NODES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   fla_alu #(
      .W (ALU_W)
   ) u_alu (
      .a     (alu_a),
      .b     (alu_b),
      .flags (alu_flags)
   );

   // exact floor(offset / NODE_BYTES) for any 16-bit offset; div_quo keeps IDX_W bits
   assign div_prod  = {{MUL_W{1'b0}}, offset_ff} * {{OFFSET_W{1'b0}}, DIV_MUL_C};
   assign div_quo   = IDX_W'(div_prod[PROD_W-1:DIV_SH]);
   assign node_base = ALU_W'(node_ff) * ALU_W'(NODE_BYTES);
   assign walk_done = (steps_ff == STEP_W'(POOL_NODES)) || (cur_ff >= LINK_END);
   assign idx_wide  = WIDE_W'(node_ff);

   always_comb begin
      case (state_ff)
         S_RANGE: begin
            alu_a = ALU_W'(offset_ff);
            alu_b = ALU_W'(POOL_BYTES);
         end
         S_ALIGN: begin
            alu_a = ALU_W'(offset_ff);
            alu_b = node_base;
         end
         S_WALK: begin
            alu_a = ALU_W'(cur_ff);
            alu_b = ALU_W'(node_ff);
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      init_cnt_in  = init_cnt_ff;
      head_in      = head_ff;
      cur_in       = cur_ff;
      node_in      = node_ff;
      steps_in     = steps_ff;
      offset_in    = offset_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      ram_we       = 1'b0;
      ram_wr_addr  = node_ff;
      ram_wr_data  = head_ff;
      ram_rd_addr  = cur_ff[IDX_W-1:0];

      case (state_ff)
         S_INIT: begin
            ram_we      = 1'b1;
            ram_wr_addr = init_cnt_ff;
            ram_wr_data = LINK_W'(init_cnt_ff) + LINK_W'(1);
            init_cnt_in = init_cnt_ff + IDX_W'(1);
            if (init_cnt_ff == IDX_W'(POOL_NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            ram_rd_addr = head_ff[IDX_W-1:0];
            if (req_valid) begin
               if (req_data.kind == KIND_FREE) begin
                  offset_in = req_data.free_offset;
                  state_in  = S_RANGE;
               end else if (head_ff >= LINK_END) begin
                  status_in = ST_EMPTY;
                  node_in   = '0;
                  state_in  = S_RESP;
               end else begin
                  node_in  = head_ff[IDX_W-1:0];
                  state_in = S_ALLOC;
               end
            end
         end
         S_ALLOC: begin
            head_in     = ram_rd_data;
            ram_we      = 1'b1;
            ram_wr_addr = node_ff;
            ram_wr_data = LINK_END;
            status_in   = ST_OK;
            state_in    = S_RESP;
         end
         S_RANGE: begin
            if (alu_flags.lt) begin
               node_in  = div_quo;
               state_in = S_ALIGN;
            end else begin
               status_in = ST_RANGE;
               node_in   = '0;
               state_in  = S_RESP;
            end
         end
         S_ALIGN: begin
            if (alu_flags.eq) begin
               cur_in   = head_ff;
               steps_in = '0;
               state_in = S_WALK;
            end else begin
               status_in = ST_UNALIGNED;
               node_in   = '0;
               state_in  = S_RESP;
            end
         end
         S_WALK: begin
            if (walk_done) begin
               ram_we      = 1'b1;
               ram_wr_addr = node_ff;
               ram_wr_data = head_ff;
               head_in     = LINK_W'(node_ff);
               status_in   = ST_OK;
               state_in    = S_RESP;
            end else if (alu_flags.eq) begin
               status_in = ST_DOUBLE;
               node_in   = '0;
               state_in  = S_RESP;
            end else begin
               steps_in = steps_ff + STEP_W'(1);
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            cur_in   = ram_rd_data;
            state_in = S_WALK;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_in.status     = status_ff;
               rsp_in.node_index = idx_wide[RSP_IDX_W-1:0];
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_cnt_ff  <= '0;
         head_ff      <= '0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         head_ff      <= head_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      node_ff   <= node_in;
      offset_ff <= offset_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- src/fla_checker.sv -----
// Port-level checker for free_list_node_allocator, attached by bind.
// Depends on fla_pkg.
module fla_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input fla_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input fla_pkg::rsp_type rsp_data
);
   import fla_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_err_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_OK) |-> rsp_data.node_index == '0)
      else $error("error response carries a node index");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in flight");

   a_no_req_payload_use: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.kind == KIND_ALLOC) |=> !rsp_valid || !$rose(rsp_valid))
      else $error("allocate response appeared in the cycle after accept");

endmodule

bind free_list_node_allocator fla_checker u_fla_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for free_list_node_allocator: random and directed requests,
// with its own model of the free list to predict each response. Depends on fla_pkg and the allocator.
module tb_top;
   import fla_pkg::*;

   localparam int POOL_N = POOL_NODES_DEF;
   localparam int NODE_B = NODE_BYTES_DEF;

   typedef struct {
      req_type payload;
      bit      wait_drain;
   } backlog_entry;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic [6:0] link_tbl [POOL_N];
   logic [6:0] free_head;

   backlog_entry request_backlog[$];
   rsp_type      outcomes[$];

   int mismatch_count = 0;
   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   bit tx_idle_on = 1'b0;
   bit rx_idle_on = 1'b0;
   int tx_gap = 0;
   int rx_stall = 0;
   bit rx_hold_arm = 1'b0;
   int rx_hold_left = 0;

   free_list_node_allocator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Pops or pushes the free list, or finds an error, and returns the response the block owes.
   function automatic rsp_type pool_outcome(input req_type r);
      rsp_type res;
      int      node;
      int      cur;
      bit      found;
      res.status = ST_OK;
      res.node_index = '0;
      if (r.kind == KIND_ALLOC) begin
         if (free_head >= POOL_N) begin
            res.status = ST_EMPTY;
         end else begin
            node = free_head;
            res.node_index = RSP_IDX_W'(node);
            free_head = link_tbl[node];
            link_tbl[node] = 7'(POOL_N);
         end
      end else if (r.free_offset >= POOL_N * NODE_B) begin
         res.status = ST_RANGE;
      end else if (r.free_offset % NODE_B != 0) begin
         res.status = ST_UNALIGNED;
      end else begin
         node = r.free_offset / NODE_B;
         found = 1'b0;
         cur = free_head;
         for (int s = 0; s < POOL_N && !found && cur < POOL_N; s++) begin
            if (cur == node) found = 1'b1;
            else cur = link_tbl[cur];
         end
         if (found) begin
            res.status = ST_DOUBLE;
         end else begin
            link_tbl[node] = free_head;
            free_head = 7'(node);
            res.node_index = RSP_IDX_W'(node);
         end
      end
      return res;
   endfunction

   task automatic flag_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
   endtask

   always @(posedge clock) begin : watch_req
      if (!reset && req_valid && req_ready) begin
         outcomes.push_back(pool_outcome(req_data));
         req_taken = 1'b1;
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_taken = 1'b1;
         if (outcomes.size() == 0) begin
            flag_mismatch("unexpected response, status", -1, rsp_data.status);
         end else begin
            want = outcomes.pop_front();
            if (rsp_data.status !== want.status)
               flag_mismatch("status", want.status, rsp_data.status);
            if (rsp_data.node_index !== want.node_index)
               flag_mismatch("node_index", want.node_index, rsp_data.node_index);
         end
      end
   end

   always @(negedge clock) begin : drive_req
      backlog_entry nxt;
      logic         nxt_valid;
      req_type      nxt_data;
      nxt_valid = req_valid;
      nxt_data = req_data;
      if (reset) begin
         nxt_valid = 1'b0;
      end else begin
         if (req_taken) begin
            nxt_valid = 1'b0;
            req_taken = 1'b0;
         end
         if (!nxt_valid) begin
            if (tx_gap > 0) begin
               tx_gap--;
            end else if (request_backlog.size() > 0 &&
                         !(request_backlog[0].wait_drain && outcomes.size() > 0)) begin
               nxt = request_backlog.pop_front();
               nxt_valid = 1'b1;
               nxt_data = nxt.payload;
               tx_gap = tx_idle_on ? $urandom_range(0, 12) : 0;
            end
         end
      end
      req_valid <= nxt_valid;
      req_data <= nxt_data;
   end

   always @(negedge clock) begin : drive_rsp_ready
      logic nxt_ready;
      if (rx_hold_arm) begin
         rx_hold_left = 400;
         rx_hold_arm = 1'b0;
      end
      if (rsp_taken) begin
         rsp_taken = 1'b0;
         rx_stall = rx_idle_on ? $urandom_range(0, 12) : 0;
      end
      if (reset) begin
         nxt_ready = 1'b0;
      end else if (rx_hold_left > 0) begin
         rx_hold_left--;
         nxt_ready = 1'b0;
      end else if (rx_stall > 0) begin
         rx_stall--;
         nxt_ready = 1'b0;
      end else begin
         nxt_ready = 1'b1;
      end
      rsp_ready <= nxt_ready;
   end

   task automatic queue_req(input logic kind, input int offset, input bit wait_drain = 1'b0);
      backlog_entry e;
      e.payload.kind = kind;
      e.payload.free_offset = OFFSET_W'(offset);
      e.wait_drain = wait_drain;
      request_backlog.push_back(e);
   endtask

   // Mostly aligned in-range frees and allocates; noise_pct of junk offsets.
   task automatic queue_mix(input int n, input int alloc_pct, input int noise_pct,
                            input bit wait_drain);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < noise_pct) begin
            if ($urandom_range(0, 1))
               queue_req(KIND_FREE, $urandom_range(0, 65535), wait_drain && i == 0);
            else
               queue_req(KIND_FREE, $urandom_range(0, POOL_N * NODE_B - 1),
                         wait_drain && i == 0);
         end else if ($urandom_range(0, 99) < alloc_pct) begin
            queue_req(KIND_ALLOC, $urandom_range(0, 65535), wait_drain && i == 0);
         end else begin
            queue_req(KIND_FREE, $urandom_range(0, POOL_N - 1) * NODE_B, wait_drain && i == 0);
         end
      end
   endtask

   task automatic wait_backlog_drained;
      while (request_backlog.size() != 0 || req_valid) @(posedge clock);
   endtask

   initial begin : stimulus
      int order [POOL_N];
      int j;
      int t;
      for (int i = 0; i < POOL_N; i++) link_tbl[i] = 7'(i + 1);
      free_head = '0;

      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      queue_req(KIND_FREE, 0);
      queue_req(KIND_FREE, (POOL_N - 1) * NODE_B);
      queue_req(KIND_FREE, POOL_N * NODE_B);
      queue_req(KIND_FREE, 16'hFFFF);
      queue_req(KIND_FREE, POOL_N * NODE_B - 1);
      queue_req(KIND_FREE, 1);
      queue_req(KIND_FREE, NODE_B / 2);
      queue_req(KIND_ALLOC, 0);
      queue_req(KIND_ALLOC, 16'hFFFF);
      queue_req(KIND_FREE, NODE_B);
      queue_req(KIND_FREE, NODE_B);
      queue_req(KIND_FREE, 0);
      queue_req(KIND_ALLOC, 16'h5555);
      queue_req(KIND_ALLOC, 16'hAAAA);
      queue_req(KIND_ALLOC, 0);
      queue_req(KIND_FREE, 2 * NODE_B);
      queue_req(KIND_FREE, 0);
      queue_req(KIND_FREE, NODE_B);
      queue_req(KIND_FREE, 16'hAAAA);
      queue_req(KIND_FREE, 16'h5555);
      queue_req(KIND_FREE, (POOL_N - 1) * NODE_B + 1);
      wait_backlog_drained();

      // empty the pool and run past the end
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      for (int i = 0; i < POOL_N + 6; i++)
         queue_req(KIND_ALLOC, $urandom_range(0, 65535), i == 0);
      wait_backlog_drained();

      // give every node back in shuffled order
      for (int i = 0; i < POOL_N; i++) order[i] = i;
      for (int i = POOL_N - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      for (int i = 0; i < POOL_N; i++) queue_req(KIND_FREE, order[i] * NODE_B, i == 0);
      wait_backlog_drained();

      queue_mix(300, 55, 10, 1'b0);
      wait_backlog_drained();

      // receiver holds off while the sender keeps pushing
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      rx_hold_arm = 1'b1;
      queue_mix(150, 50, 10, 1'b0);
      wait_backlog_drained();

      rx_idle_on = 1'b1;
      queue_mix(250, 30, 10, 1'b1);
      wait_backlog_drained();

      tx_idle_on = 1'b1;
      rx_idle_on = 1'b0;
      queue_mix(300, 70, 10, 1'b1);
      wait_backlog_drained();

      while (outcomes.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (outcomes.size() != 0) begin
         $display("%0d responses never arrived", outcomes.size());
         mismatch_count += outcomes.size();
      end
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
